FILE: hw/rtl/qebc_pkg.sv
// Shared types and codes for the quadrature encoder and button counter.
// Holds the item structs, command and direction codes, and step patterns.
// Depends on nothing.
`default_nettype none

package qebc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic [1:0] HIST_00 = 2'h0;
  localparam logic [1:0] HIST_01 = 2'h1;
  localparam logic [1:0] HIST_10 = 2'h2;
  localparam logic [1:0] HIST_11 = 2'h3;

  typedef struct packed {
    logic [1:0] cmd;
    logic       line_a;
    logic       line_b;
    logic       button_low;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           direction;
    logic [OUT_WIDTH-1:0] turn_count;
    logic                 pressed;
    logic [OUT_WIDTH-1:0] press_total;
    logic                 change_pending;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/quadrature_encoder_button_counter_core.sv
// Quadrature encoder decoder with push button press counter.
// Uses qebc_pkg for item types, command codes and step patterns.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one command per item:
//   sample the pins, read and clear the totals, or restart the line history.
//   Result channel (out_valid/out_ready/out_item) returns exactly one item for
//   every input item, in order.
//   An accepted item lands in the input register, and its result is written
//   to the output register when that register is empty or being read, which
//   a stall can delay. Throughput: one item per clock while out_ready
//   stays high.
//   Counter and history updates happen as an item moves from the input
//   register to the output register.
//   When the receiver stalls, the result holds in the output register, the
//   next item waits in the input register, and in_ready drops once both are
//   full; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   histories, the step and press counters and the change flag.
`default_nettype none

module quadrature_encoder_button_counter_core
  import qebc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [1:0]             hist_a_r, hist_a_nxt;
  logic [1:0]             hist_b_r, hist_b_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  logic [COUNT_WIDTH-1:0] right_r, right_nxt;
  logic [COUNT_WIDTH-1:0] press_r, press_nxt;
  logic                   change_r, change_nxt;
  out_item_t              res_nxt;

  logic                   s1_adv;
  logic                   in_acc;
  logic [1:0]             sh_a, sh_b;
  logic                   is_left, is_right;
  logic [COUNT_WIDTH-1:0] diff_lr, diff_rl;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign sh_a = {hist_a_r[0], s1_item_r.line_a};
  assign sh_b = {hist_b_r[0], s1_item_r.line_b};

  assign is_left  = (sh_a == HIST_11 && sh_b == HIST_01) ||
                    (sh_a == HIST_00 && sh_b == HIST_10);
  assign is_right = (sh_a == HIST_01 && sh_b == HIST_11) ||
                    (sh_a == HIST_10 && sh_b == HIST_00);

  assign diff_lr = left_r - right_r;
  assign diff_rl = right_r - left_r;

  always_comb begin
    hist_a_nxt = hist_a_r;
    hist_b_nxt = hist_b_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    press_nxt  = press_r;
    change_nxt = change_r;
    res_nxt    = '0;
    unique case (s1_item_r.cmd)
      CMD_SAMPLE: begin
        if (!s1_item_r.button_low) begin
          press_nxt  = press_r + 1'b1;
          change_nxt = 1'b1;
        end else begin
          hist_a_nxt = sh_a;
          hist_b_nxt = sh_b;
          if (is_left) begin
            left_nxt   = left_r + 1'b1;
            change_nxt = 1'b1;
          end
          if (is_right) begin
            right_nxt  = right_r + 1'b1;
            change_nxt = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (left_r > right_r) begin
          res_nxt.direction  = DIR_LEFT;
          res_nxt.turn_count = OUT_WIDTH'(diff_lr);
        end else if (left_r < right_r) begin
          res_nxt.direction  = DIR_RIGHT;
          res_nxt.turn_count = OUT_WIDTH'(diff_rl);
        end else begin
          res_nxt.direction  = DIR_NONE;
        end
        res_nxt.pressed     = (press_r != '0);
        res_nxt.press_total = OUT_WIDTH'(press_r);
        left_nxt   = '0;
        right_nxt  = '0;
        press_nxt  = '0;
        change_nxt = 1'b0;
      end
      CMD_RESTART: begin
        hist_a_nxt = HIST_00;
        hist_b_nxt = HIST_00;
        change_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    res_nxt.change_pending = change_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_a_r    <= '0;
      hist_b_r    <= '0;
      left_r      <= '0;
      right_r     <= '0;
      press_r     <= '0;
      change_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        hist_a_r    <= hist_a_nxt;
        hist_b_r    <= hist_b_nxt;
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        press_r     <= press_nxt;
        change_r    <= change_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: hw/rtl/qebc_checker.sv
// Port-level checks for quadrature_encoder_button_counter_core.
// Uses qebc_pkg for item types and direction codes; bound to the top level.
`default_nettype none

module qebc_checker
  import qebc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.direction == DIR_NONE |-> out_item.turn_count == '0)
    else $error("turn count without direction");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.direction != DIR_NONE || out_item.press_total != '0)
      |-> !out_item.change_pending && (out_item.press_total == '0 || out_item.pressed))
    else $error("read result left change flag set or missed press");

endmodule

bind quadrature_encoder_button_counter_core qebc_checker u_qebc_checker (.*);

`default_nettype wire

FILE: dv/quadrature_encoder_button_counter_core_test.sv
// Self-checking testbench for quadrature_encoder_button_counter_core.
// Predicts each result from its own copy of the decoder state and checks
// every output item in order; depends on qebc_pkg and the core RTL.
module quadrature_encoder_button_counter_core_test;
  import qebc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         LIMIT_CYCLES = 1_500_000;
  localparam int         STALL_CYCLES = 300;
  localparam int         SHOW_MAX     = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  quadrature_encoder_button_counter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as predicted
  logic [1:0]                 hist_a, hist_b;
  logic [COUNT_WIDTH_DEF-1:0] left_cnt, right_cnt, press_cnt;
  logic                       change_flag;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int   items_queued   = 0;
  int   items_accepted = 0;
  int   results_seen   = 0;
  int   errors         = 0;
  int   cycles         = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  logic in_fired       = 1'b0;
  logic hold_go        = 1'b0;
  logic hold_on        = 1'b0;
  int   walk_pos       = 0;
  int   walk_dir       = 1;

  function automatic out_item_t decode_item(in_item_t it);
    out_item_t r;
    r = '0;
    r.direction = DIR_NONE;
    case (it.cmd)
      CMD_SAMPLE: begin
        if (!it.button_low) begin
          change_flag = 1'b1;
          press_cnt   = press_cnt + 1'b1;
        end else begin
          hist_a = {hist_a[0], it.line_a};
          hist_b = {hist_b[0], it.line_b};
          if ((hist_a == HIST_11 && hist_b == HIST_01) ||
              (hist_a == HIST_00 && hist_b == HIST_10)) begin
            change_flag = 1'b1;
            left_cnt    = left_cnt + 1'b1;
          end
          if ((hist_a == HIST_01 && hist_b == HIST_11) ||
              (hist_a == HIST_10 && hist_b == HIST_00)) begin
            change_flag = 1'b1;
            right_cnt   = right_cnt + 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (left_cnt > right_cnt) begin
          r.direction  = DIR_LEFT;
          r.turn_count = left_cnt - right_cnt;
        end else if (left_cnt < right_cnt) begin
          r.direction  = DIR_RIGHT;
          r.turn_count = right_cnt - left_cnt;
        end
        r.pressed     = (press_cnt != '0);
        r.press_total = press_cnt;
        left_cnt      = '0;
        right_cnt     = '0;
        press_cnt     = '0;
        change_flag   = 1'b0;
      end
      CMD_RESTART: begin
        hist_a      = HIST_00;
        hist_b      = HIST_00;
        change_flag = 1'b0;
      end
      default: begin
      end
    endcase
    r.change_pending = change_flag;
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] cmd, input logic a, input logic b,
                            input logic btn);
    in_item_t it;
    it.cmd        = cmd;
    it.line_a     = a;
    it.line_b     = b;
    it.button_low = btn;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Mostly a quadrature walk with random direction changes, plus noise, presses, reads, restarts and unused commands
  task automatic queue_random_item();
    int  pick;
    int  k;
    logic a, b;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      k = $urandom_range(0, 9);
      if (k < 7) walk_pos = (walk_pos + walk_dir + 4) % 4;
      else if (k == 9) walk_dir = -walk_dir;
      a = (walk_pos == 1 || walk_pos == 2);
      b = (walk_pos >= 2);
      queue_item(CMD_SAMPLE, a, b, 1'b1);
    end else if (pick < 65) begin
      queue_item(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end else if (pick < 75) begin
      queue_item(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    end else if (pick < 85) begin
      queue_item(CMD_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end else if (pick < 92) begin
      queue_item(CMD_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end else begin
      queue_item(CMD_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || results_seen != items_accepted)
      @(negedge clk);
    @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_in
    in_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_fired || !in_valid) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_item  <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : long_stall
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("[%0t] unexpected result item: %p", $realtime, out_item);
        end else begin
          want = expected_results.pop_front();
          bad  = (out_item.direction      !== want.direction)   ||
                 (out_item.turn_count     !== want.turn_count)  ||
                 (out_item.pressed        !== want.pressed)     ||
                 (out_item.press_total    !== want.press_total) ||
                 (out_item.change_pending !== want.change_pending);
          if (bad) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display("[%0t] result %0d mismatch: expected ", $realtime, results_seen,
                       "dir=%0d turns=%0d pr=%0b tot=%0d chg=%0b, ",
                       want.direction, want.turn_count, want.pressed,
                       want.press_total, want.change_pending,
                       "got dir=%0d turns=%0d pr=%0b tot=%0d chg=%0b",
                       out_item.direction, out_item.turn_count, out_item.pressed,
                       out_item.press_total, out_item.change_pending);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_item(in_item));
        items_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("quadrature_encoder_button_counter_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    hist_a      = HIST_00;
    hist_b      = HIST_00;
    left_cnt    = '0;
    right_cnt   = '0;
    press_cnt   = '0;
    change_flag = 1'b0;
    rst_n       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 65;
    queue_item(CMD_UNUSED, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_READ, 1'b0, 1'b0, 1'b0);
    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b1);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
    queue_item(CMD_UNUSED, 1'b0, 1'b0, 1'b1);
    queue_item(CMD_READ, 1'b1, 1'b1, 1'b1);
    queue_item(CMD_RESTART, 1'b0, 1'b0, 1'b1);
    queue_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b1);
    queue_item(CMD_RESTART, 1'b1, 1'b1, 1'b0);
    queue_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);
    queue_item(CMD_RESTART, 1'b0, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b1);
    queue_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b1);
    queue_item(CMD_READ, 1'b0, 1'b1, 1'b0);
    queue_item(CMD_RESTART, 1'b1, 1'b0, 1'b0);
    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b1);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);
    queue_item(CMD_READ, 1'b1, 1'b0, 1'b1);
    repeat (480) queue_random_item();
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 29;
    repeat (480) queue_random_item();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) queue_random_item();
    hold_go = 1'b1;
    wait_drained();
    repeat (270) queue_random_item();
    wait_drained();

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) errors++;

    $display("Run covered %0d items and %0d results under three idling mixes,",
             items_accepted, results_seen);
    $display("and a %0d-cycle output stall with the input side backed up.",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("quadrature_encoder_button_counter_core regression: pass");
    end else begin
      $display("quadrature_encoder_button_counter_core regression: fail");
    end
    $finish;
  end

endmodule
